@@ hdl/nfal_pkg.sv @@
// Shared constants, codes and types of the next-fit entry allocator.
package nfal_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int LIM_W     = $clog2(ENTRIES + 1);
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WORDS     = ENTRIES / WORD_BITS;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int ROW_W     = 2 * WORD_BITS;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int LSTATE_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BUSY        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_WRONG_STATE = 3'd4;

    localparam logic [LSTATE_W-1:0] LSTATE_UNLOCKED = 2'd0;
    localparam logic [LSTATE_W-1:0] LSTATE_WRITE    = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_MIN   = LIM_W'(2);
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [ROW_W-1:0]   wr_data;
    } bitmap_req_t;

endpackage

@@ hdl/nfal_bitmap.sv @@
// Bitmap memory of allocated and lock bits, 32 entries per row, with per-row valid bits.
module nfal_bitmap
    import nfal_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  bitmap_req_t      req,
    output logic [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [WORDS];
    logic [WORDS-1:0] row_valid_reg;
    logic [ROW_W-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (req.rd_en) begin
                rvalid_reg <= row_valid_reg[req.rd_addr];
            end
            if (req.wr_en) begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    // A row never written since reset reads as all clear.
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hdl/next_fit_entry_allocator_with_locks.sv @@
// Top level of the next-fit entry allocator with per-entry locks.
//
// Requests enter on the s_ stream channel and each gives exactly one result
// on the m_ stream channel. The table limit is written through the cfg_
// channel, which is always ready; it should only be written while the block
// is idle. Load, free, lock, unlock, query and unknown commands read the
// bitmap row at the accepting edge, then, once the output register is free,
// write it back when the command updates it and present the result. Alloc
// reads one row of 32 entries per cycle from the bitmap memory, pipelined,
// while the output register is free, starting at the row of the rotating
// start pointer and wrapping to the first row. One request is worked on at
// a time; the next is accepted as soon as the previous result sits in the
// output register. If the receiver stalls, the finished result waits
// there and the following request halts before it would write the bitmap.
// Reset clears all allocated and lock bits at once through per-row valid
// flags, sets the start pointer to 1 and the limit to 1024; no clearing
// pass is needed.
module next_fit_entry_allocator_with_locks
    import nfal_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd[2:0], entry_index[12:3], lifetime_set[13], intent_set[14], zero[15]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], granted_index[12:3], lock_state[14:13], zero[15]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIM_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    logic [LIM_W-1:0]      cfg_limit_reg;
    logic [IDX_W-1:0]      search_start_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  life_reg;
    logic                  intent_reg;
    logic                  idx_ok_reg;
    logic [IDX_W-1:0]      start_reg;
    logic [WADDR_W-1:0]    rd_word_reg;
    logic                  rd_phase_reg;
    logic                  rd_done_reg;
    logic                  ev_valid_reg;
    logic [WADDR_W-1:0]    ev_word_reg;
    logic                  ev_phase_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [CMD_W-1:0]    in_cmd;
    logic [IDX_W-1:0]    in_idx;
    logic [LIM_W-1:0]    limit;
    logic [IDX_W-1:0]    limit_m1;
    logic [WADDR_W-1:0]  last_word;
    logic                in_idx_ok;
    logic [IDX_W-1:0]    eff_start;
    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                scan_adv;
    logic                set_start;
    logic [STATUS_W-1:0] out_status;
    logic [IDX_W-1:0]    out_grant;
    logic [LSTATE_W-1:0] out_lstate;

    bitmap_req_t      mreq;
    logic [ROW_W-1:0] rd_data;

    logic [BIT_W-1:0]    ex_bit;
    logic                ex_alloc;
    logic                ex_lock;
    logic [STATUS_W-1:0] ex_status;
    logic [LSTATE_W-1:0] ex_lstate;
    logic                ex_wr;
    logic [ROW_W-1:0]    ex_wdata;

    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;
    logic [IDX_W-1:0]     grant_idx;
    logic [ROW_W-1:0]     scan_wdata;

    nfal_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_idx    = s_tdata[CMD_W+IDX_W-1:CMD_W];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        if (cfg_limit_reg > LIMIT_RESET) begin
            limit = LIMIT_RESET;
        end else if (cfg_limit_reg < LIMIT_MIN) begin
            limit = LIMIT_MIN;
        end else begin
            limit = cfg_limit_reg;
        end
    end

    assign limit_m1  = IDX_W'(limit - LIM_W'(1));
    assign last_word = limit_m1[IDX_W-1:BIT_W];
    assign in_idx_ok = (in_idx != '0) && (LIM_W'(in_idx) < limit);
    assign eff_start = ((search_start_reg == '0) || (LIM_W'(search_start_reg) >= limit))
                       ? IDX_W'(1) : search_start_reg;

    // Single-entry commands on the row read when the request was accepted.
    assign ex_bit   = idx_reg[BIT_W-1:0];
    assign ex_alloc = rd_data[ex_bit];
    assign ex_lock  = rd_data[WORD_BITS + int'(ex_bit)];

    always_comb begin
        ex_status = STAT_OK;
        ex_lstate = LSTATE_UNLOCKED;
        ex_wr     = 1'b0;
        ex_wdata  = rd_data;
        if (cmd_reg > CMD_QUERY) begin
            ex_status = STAT_WRONG_STATE;
        end else if (!idx_ok_reg) begin
            ex_status = STAT_BAD_INDEX;
        end else begin
            unique case (cmd_reg)
                CMD_LOAD: begin
                    ex_wr            = 1'b1;
                    ex_wdata[ex_bit] = life_reg && !intent_reg;
                end
                CMD_FREE: begin
                    if (ex_alloc && ex_lock) begin
                        ex_wr                                = 1'b1;
                        ex_wdata[ex_bit]                     = 1'b0;
                        ex_wdata[WORD_BITS + int'(ex_bit)]   = 1'b0;
                    end else begin
                        ex_status = STAT_WRONG_STATE;
                    end
                end
                CMD_LOCK: begin
                    if (ex_lock) begin
                        ex_status = STAT_BUSY;
                    end else begin
                        ex_wr                              = 1'b1;
                        ex_wdata[WORD_BITS + int'(ex_bit)] = 1'b1;
                    end
                end
                CMD_UNLOCK: begin
                    if (ex_lock) begin
                        ex_wr                              = 1'b1;
                        ex_wdata[WORD_BITS + int'(ex_bit)] = 1'b0;
                    end else begin
                        ex_status = STAT_WRONG_STATE;
                    end
                end
                CMD_QUERY: begin
                    ex_lstate = ex_lock ? LSTATE_WRITE : LSTATE_UNLOCKED;
                end
                default: begin
                    ex_status = STAT_WRONG_STATE;
                end
            endcase
        end
    end

    // Free entries of the row under evaluation within the current search window.
    always_comb begin
        logic [IDX_W-1:0] gidx;
        for (int b = 0; b < WORD_BITS; b++) begin
            gidx = {ev_word_reg, BIT_W'(b)};
            if (!ev_phase_reg) begin
                free_vec[b] = !rd_data[b] && !rd_data[WORD_BITS + b]
                              && (gidx >= start_reg) && (LIM_W'(gidx) < limit);
            end else begin
                free_vec[b] = !rd_data[b] && !rd_data[WORD_BITS + b]
                              && (gidx != '0) && (gidx < start_reg);
            end
        end
    end

    always_comb begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                found     = 1'b1;
                found_bit = BIT_W'(b);
            end
        end
    end

    assign grant_idx = {ev_word_reg, found_bit};

    always_comb begin
        scan_wdata                                 = rd_data;
        scan_wdata[found_bit]                      = 1'b1;
        scan_wdata[WORD_BITS + int'(found_bit)]    = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mreq       = '0;
        load_out   = 1'b0;
        scan_adv   = 1'b0;
        set_start  = 1'b0;
        out_status = STAT_OK;
        out_grant  = '0;
        out_lstate = LSTATE_UNLOCKED;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_ALLOC) begin
                        state_next = ST_SCAN;
                    end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = in_idx[IDX_W-1:BIT_W];
                        state_next   = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    out_status   = ex_status;
                    out_lstate   = ex_lstate;
                    mreq.wr_en   = ex_wr;
                    mreq.wr_addr = idx_reg[IDX_W-1:BIT_W];
                    mreq.wr_data = ex_wdata;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    scan_adv     = 1'b1;
                    mreq.rd_en   = !rd_done_reg;
                    mreq.rd_addr = rd_word_reg;
                    if (ev_valid_reg) begin
                        if (found) begin
                            load_out     = 1'b1;
                            out_grant    = grant_idx;
                            set_start    = 1'b1;
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = ev_word_reg;
                            mreq.wr_data = scan_wdata;
                            state_next   = ST_IDLE;
                        end else if (ev_phase_reg
                                     && (ev_word_reg == start_reg[IDX_W-1:BIT_W])) begin
                            load_out   = 1'b1;
                            out_status = STAT_NONE_FREE;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_limit_reg    <= LIMIT_RESET;
            search_start_reg <= IDX_W'(1);
            m_tvalid_reg     <= 1'b0;
            ev_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_limit_reg <= cfg_data;
            end
            if (set_start) begin
                search_start_reg <= grant_idx;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept) begin
                ev_valid_reg <= 1'b0;
            end else if (scan_adv) begin
                ev_valid_reg <= !rd_done_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= in_cmd;
            idx_reg      <= in_idx;
            life_reg     <= s_tdata[CMD_W+IDX_W];
            intent_reg   <= s_tdata[CMD_W+IDX_W+1];
            idx_ok_reg   <= in_idx_ok;
            start_reg    <= eff_start;
            rd_word_reg  <= eff_start[IDX_W-1:BIT_W];
            rd_phase_reg <= 1'b0;
            rd_done_reg  <= 1'b0;
        end else if (scan_adv) begin
            ev_word_reg  <= rd_word_reg;
            ev_phase_reg <= rd_phase_reg;
            if (!rd_done_reg) begin
                if (!rd_phase_reg && (rd_word_reg == last_word)) begin
                    rd_phase_reg <= 1'b1;
                    rd_word_reg  <= '0;
                end else if (rd_phase_reg
                             && (rd_word_reg == start_reg[IDX_W-1:BIT_W])) begin
                    rd_done_reg <= 1'b1;
                end else begin
                    rd_word_reg <= rd_word_reg + WADDR_W'(1);
                end
            end
        end
        if (load_out) begin
            m_tdata_reg <= {1'b0, out_lstate, out_grant, out_status};
        end
    end

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.wr_en |-> (state_reg != ST_IDLE))
        else $error("bitmap written while idle");

    a_grant_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg[IDX_W+STATUS_W-1:STATUS_W] != '0))
        |-> (m_tdata_reg[STATUS_W-1:0] == STAT_OK))
        else $error("granted index with failing status");

    a_lstate_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg[OUT_DATA_W-2:IDX_W+STATUS_W] != LSTATE_UNLOCKED))
        |-> (m_tdata_reg[STATUS_W-1:0] == STAT_OK))
        else $error("lock state reported with failing status");

    a_start_follows_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        set_start |=> (search_start_reg == m_tdata_reg[IDX_W+STATUS_W-1:STATUS_W]))
        else $error("start pointer does not match granted entry");

    a_scan_write_hits_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (mreq.wr_en && (state_reg == ST_SCAN)) |-> (found && ev_valid_reg))
        else $error("alloc wrote a row without a free entry");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the next-fit entry allocator with per-entry locks.
module testbench;
    import nfal_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
    localparam int NUM_STATUS = 5;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic             lifetime;
        logic             intent;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted;
        logic [LSTATE_W-1:0] lstate;
    } answer_t;

    class allocator_scoreboard;
        bit               allocated[ENTRIES];
        bit               locked[ENTRIES];
        int unsigned      next_start;
        logic [LIM_W-1:0] entries_reg;
        answer_t          awaited_q[$];
        int unsigned      mismatches;
        int unsigned      status_seen[NUM_STATUS];

        function new();
            next_start  = 1;
            entries_reg = LIMIT_RESET;
            mismatches  = 0;
        endfunction

        function void write_limit(logic [LIM_W-1:0] value);
            entries_reg = value;
        endfunction

        function int unsigned table_limit();
            int unsigned n;
            n = entries_reg;
            if (n > ENTRIES) n = ENTRIES;
            if (n < LIMIT_MIN) n = LIMIT_MIN;
            return n;
        endfunction

        function answer_t note_request(request_t r);
            answer_t     a;
            int unsigned lim;
            int unsigned first;
            int unsigned pos;
            bit          exhausted;
            bit          in_range;
            lim       = table_limit();
            a.status  = STAT_OK;
            a.granted = '0;
            a.lstate  = LSTATE_UNLOCKED;
            in_range  = (r.idx != 0) && (r.idx < lim);
            if (r.cmd == CMD_ALLOC) begin
                first = next_start;
                if (first == 0 || first >= lim) first = 1;
                pos       = first;
                exhausted = 1'b0;
                while (!exhausted && (allocated[pos] || locked[pos])) begin
                    pos++;
                    if (pos >= lim) pos = 1;
                    if (pos == first) exhausted = 1'b1;
                end
                if (exhausted) begin
                    a.status = STAT_NONE_FREE;
                end else begin
                    allocated[pos] = 1'b1;
                    locked[pos]    = 1'b1;
                    next_start     = pos;
                    a.granted      = IDX_W'(pos);
                end
            end else if (r.cmd > CMD_QUERY) begin
                a.status = STAT_WRONG_STATE;
            end else if (!in_range) begin
                a.status = STAT_BAD_INDEX;
            end else begin
                case (r.cmd)
                    CMD_LOAD: begin
                        allocated[r.idx] = r.lifetime && !r.intent;
                    end
                    CMD_FREE: begin
                        if (allocated[r.idx] && locked[r.idx]) begin
                            allocated[r.idx] = 1'b0;
                            locked[r.idx]    = 1'b0;
                        end else begin
                            a.status = STAT_WRONG_STATE;
                        end
                    end
                    CMD_LOCK: begin
                        if (locked[r.idx]) a.status = STAT_BUSY;
                        else locked[r.idx] = 1'b1;
                    end
                    CMD_UNLOCK: begin
                        if (locked[r.idx]) locked[r.idx] = 1'b0;
                        else a.status = STAT_WRONG_STATE;
                    end
                    default: begin
                        a.lstate = locked[r.idx] ? LSTATE_WRITE : LSTATE_UNLOCKED;
                    end
                endcase
            end
            awaited_q.push_back(a);
            status_seen[a.status]++;
            return a;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            answer_t want;
            if (awaited_q.size() == 0) begin
                report($sformatf("result %h arrived with no request outstanding", d));
                return;
            end
            want = awaited_q.pop_front();
            if (d[2:0] !== want.status)
                report($sformatf("status %0d, expected %0d", d[2:0], want.status));
            if (d[12:3] !== want.granted)
                report($sformatf("granted index %0d, expected %0d", d[12:3], want.granted));
            if (d[14:13] !== want.lstate)
                report($sformatf("lock state %0d, expected %0d", d[14:13], want.lstate));
            if (d[OUT_DATA_W-1] !== 1'b0)
                report("padding bit of the result is not zero");
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LIM_W-1:0]      cfg_data  = '0;

    allocator_scoreboard sb;
    bit                  tx_idle       = 1'b1;
    bit                  rx_idle       = 1'b1;
    int unsigned         long_hold     = 0;
    int unsigned         request_count = 0;
    int unsigned         limit_count   = 0;
    int unsigned         grant_pool[$];

    next_fit_entry_allocator_with_locks u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic request_t make_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                              logic lifetime, logic intent);
        request_t r;
        r.cmd      = cmd;
        r.idx      = idx;
        r.lifetime = lifetime;
        r.intent   = intent;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned lim;
        int unsigned slot;
        int unsigned k;
        lim = sb.table_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return IDX_W'($urandom_range(0, ENTRIES - 1));
            2: return (lim < ENTRIES) ? IDX_W'($urandom_range(lim, ENTRIES - 1))
                                      : IDX_W'(lim - 1);
            3, 4, 5: begin
                if (grant_pool.size() != 0) begin
                    k    = $urandom_range(0, grant_pool.size() - 1);
                    slot = grant_pool[k];
                    grant_pool.delete(k);
                    return IDX_W'(slot);
                end
            end
            default: ;
        endcase
        return IDX_W'($urandom_range(1, lim - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return CMD_ALLOC;
        if (roll < 48) return CMD_FREE;
        if (roll < 60) return CMD_LOCK;
        if (roll < 72) return CMD_UNLOCK;
        if (roll < 82) return CMD_QUERY;
        if (roll < 96) return CMD_LOAD;
        return roll[0] ? CMD_UNKNOWN_HI : CMD_UNKNOWN_LO;
    endfunction

    task automatic send_request(input request_t r, output answer_t a);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.intent, r.lifetime, r.idx, r.cmd};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        a = sb.note_request(r);
        request_count++;
        if (r.cmd == CMD_ALLOC && a.status == STAT_OK) grant_pool.push_back(a.granted);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_limit(value);
        limit_count++;
    endtask

    task automatic run_phase(input int unsigned items);
        int unsigned      sent;
        answer_t          a;
        logic [IDX_W-1:0] slot;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 4))
                0: begin
                    send_request(make_request(CMD_ALLOC, IDX_W'($urandom), 1'b0, 1'b0), a);
                    sent++;
                    if (a.status == STAT_OK) begin
                        void'(grant_pool.pop_back());
                        send_request(make_request(CMD_FREE, a.granted,
                                                  1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))), a);
                        sent++;
                    end
                end
                1: begin
                    slot = pick_index();
                    send_request(make_request(CMD_LOCK, slot, 1'b0, 1'b0), a);
                    send_request(make_request(CMD_QUERY, slot, 1'b0, 1'b0), a);
                    send_request(make_request(CMD_UNLOCK, slot, 1'b0, 1'b0), a);
                    sent += 3;
                end
                2: begin
                    slot = pick_index();
                    send_request(make_request(CMD_LOAD, slot, 1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1))), a);
                    send_request(make_request(CMD_QUERY, slot, 1'b0, 1'b0), a);
                    sent += 2;
                end
                default: begin
                    send_request(make_request(pick_command(), pick_index(),
                                              1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1))), a);
                    sent++;
                end
            endcase
        end
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold != 0) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
                if (m_tvalid && m_tready) sb.check_result(m_tdata);
            end
        end
    end

    initial begin
        request_t opening[$];
        answer_t  a;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        opening.push_back(make_request(CMD_QUERY, 10'd0, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOAD, 10'd1023, 1'b1, 1'b0));
        opening.push_back(make_request(CMD_QUERY, 10'd1023, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_ALLOC, 10'd1023, 1'b1, 1'b1));
        opening.push_back(make_request(CMD_FREE, 10'd1, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_FREE, 10'd1, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOCK, 10'd5, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOCK, 10'd5, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_QUERY, 10'd5, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_UNLOCK, 10'd5, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_UNLOCK, 10'd5, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOAD, 10'd3, 1'b1, 1'b1));
        opening.push_back(make_request(CMD_LOAD, 10'd4, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOAD, 10'd2, 1'b0, 1'b1));
        opening.push_back(make_request(CMD_FREE, 10'd2, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_QUERY, 10'd2, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_UNKNOWN_LO, 10'd7, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_UNKNOWN_HI, 10'd1023, 1'b1, 1'b1));
        opening.push_back(make_request(CMD_LOCK, 10'd0, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_FREE, 10'd1023, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_LOCK, 10'd1023, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_FREE, 10'd1023, 1'b0, 1'b0));
        opening.push_back(make_request(CMD_ALLOC, 10'd0, 1'b0, 1'b0));
        foreach (opening[i]) send_request(opening[i], a);

        run_phase(80);
        // Lowering the limit leaves the search start pointer beyond the table.
        set_limit(LIM_W'(2));
        run_phase(60);
        set_limit('0);
        run_phase(40);
        set_limit(LIM_W'(3));
        run_phase(70);
        set_limit('1);
        run_phase(90);
        set_limit(LIM_W'(37));
        long_hold = 300;
        run_phase(100);
        set_limit(LIM_W'(33));
        run_phase(90);
        set_limit(LIM_W'($urandom_range(2, ENTRIES)));
        run_phase(90);
        set_limit(LIM_W'(1));
        run_phase(40);
        set_limit(LIM_W'(64));
        run_phase(100);
        set_limit(LIM_W'(1500));
        run_phase(60);
        set_limit(LIMIT_RESET);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_phase(90);

        settle();
        repeat (40) @(posedge aclk);

        $display("%0d requests run under %0d table limits, from two slots to the full table.",
                 request_count, limit_count + 1);
        $display("Answers seen: %0d ok, %0d none free, %0d busy, %0d bad index, %0d wrong state.",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_NONE_FREE],
                 sb.status_seen[STAT_BUSY], sb.status_seen[STAT_BAD_INDEX],
                 sb.status_seen[STAT_WRONG_STATE]);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/nfal_pkg.sv
hdl/nfal_bitmap.sv
hdl/next_fit_entry_allocator_with_locks.sv
tb/sv/testbench.sv
